>>> hdl/bhtr_pkg.sv
// Package for the bucketed hash table: operation codes, slot layout and
// default sizes. No dependencies.
package bhtr_pkg;

   // Default table geometry.
   localparam int BUCKETS_DEFAULT          = 1024;
   localparam int WAYS_DEFAULT             = 3;
   localparam int GENERATION_RANGE_DEFAULT = 64;
   localparam int FILL_SAMPLES_DEFAULT     = 1000;

   // Value of the bucket count register after reset.
   localparam logic [10:0] BUCKET_COUNT_RESET = 11'd1024;

   // Operation codes carried by the request beat.
   typedef enum logic [1:0] {
      OP_STORE = 2'd0,
      OP_PROBE = 2'd1,
      OP_FILL  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   // Bound code that always allows an overwrite on a matching tag.
   localparam logic [1:0] BOUND_EXACT = 2'd0;

   // One slot of a bucket as held in memory.
   typedef struct packed {
      logic              valid;
      logic signed [7:0] depth;
      logic [5:0]        gen;
      logic [1:0]        bound;
      logic [15:0]       tag;
      logic signed [15:0] eval;
      logic signed [15:0] score;
      logic [15:0]       move;
   } slot_type;

endpackage

>>> hdl/bhtr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Used for the bucket store of the hash table; no dependencies.
module bhtr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/bucketed_hash_table_replacement.sv
// Set-associative result table: a store or probe passes through accept, key
// scaling multiply, bucket read, and update and write-back of one bucket word;
// a probe whose response is still held by rsp_ready stays in the update step.
// Count fill reads one bucket row per cycle over the sampled rows (334 at the
// defaults), then finishes the sum and loads the result, waiting while the
// response register is still held; clear accepts, then writes one row per
// bucket. After reset the same clearing pass runs before the first
// request is taken.
// Depends on bhtr_pkg and bhtr_ram.
module bucketed_hash_table_replacement #(
   parameter int BUCKETS          = bhtr_pkg::BUCKETS_DEFAULT,
   parameter int WAYS             = bhtr_pkg::WAYS_DEFAULT,
   parameter int GENERATION_RANGE = bhtr_pkg::GENERATION_RANGE_DEFAULT,
   parameter int FILL_SAMPLES     = bhtr_pkg::FILL_SAMPLES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [10:0]        csr_write_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_operation,
   input  logic [63:0]        req_key,
   input  logic [5:0]         req_generation,
   input  logic [15:0]        req_move_in,
   input  logic signed [15:0] req_score_in,
   input  logic signed [15:0] req_eval_in,
   input  logic signed [7:0]  req_depth_in,
   input  logic [1:0]         req_bound_in,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_hit,
   output logic [15:0]        rsp_move_out,
   output logic signed [15:0] rsp_score_out,
   output logic signed [15:0] rsp_eval_out,
   output logic signed [7:0]  rsp_depth_out,
   output logic [1:0]         rsp_bound_out,
   output logic [9:0]         rsp_fill_count
);

   import bhtr_pkg::*;

   localparam int BW        = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int WIX       = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int AGW       = $clog2(GENERATION_RANGE);
   localparam int SLOTS     = BUCKETS * WAYS;
   localparam int NSAMP     = (FILL_SAMPLES < SLOTS) ? FILL_SAMPLES : SLOTS;
   localparam int FROWS     = (NSAMP + WAYS - 1) / WAYS;
   localparam int LAST_WAYS = NSAMP - (FROWS - 1) * WAYS;
   localparam int FRW       = (FROWS > 1) ? $clog2(FROWS) : 1;
   localparam int CW        = $clog2(WAYS + 1);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_MUL  = 7'b0000010,
      S_RD   = 7'b0000100,
      S_EXE  = 7'b0001000,
      S_FILL = 7'b0010000,
      S_FEND = 7'b0100000,
      S_CLR  = 7'b1000000
   } state_type;

   typedef slot_type [WAYS-1:0] row_type;

   state_type state_ff, state_in;

   // Configuration register.
   logic [10:0] bc_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         bc_ff <= BUCKET_COUNT_RESET;
      end else if (csr_write_enable) begin
         bc_ff <= csr_write_data;
      end
   end

   // Request capture.
   op_type             op_ff;
   logic [63:0]        key_ff;
   logic [5:0]         gen_ff;
   logic [15:0]        move_ff;
   logic signed [15:0] score_ff;
   logic signed [15:0] eval_ff;
   logic signed [7:0]  depth_ff;
   logic [1:0]         bound_ff;
   logic               req_fire;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff    <= op_type'(req_operation);
         key_ff   <= req_key;
         gen_ff   <= req_generation;
         move_ff  <= req_move_in;
         score_ff <= req_score_in;
         eval_ff  <= req_eval_in;
         depth_ff <= req_depth_in;
         bound_ff <= req_bound_in;
      end
   end

   // Bucket index: high 11 bits of the product of the key and the clamped bucket count.
   logic [10:0]   bc_eff;
   logic [74:0]   prod;
   logic [BW-1:0] bucket_ff;
   assign bc_eff = (32'(bc_ff) > BUCKETS) ? 11'(BUCKETS) : bc_ff;
   assign prod   = {11'd0, key_ff} * {64'd0, bc_eff};
   always_ff @(posedge clock) begin
      if (state_ff == S_MUL) begin
         bucket_ff <= BW'(prod[74:64]);
      end
   end

   // Bucket memory.
   logic          wr_en, rd_en;
   logic [BW-1:0] wr_addr, rd_addr;
   row_type       wr_row, rd_row;

   bhtr_ram #(
      .WIDTH ($bits(row_type)),
      .DEPTH (BUCKETS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_row),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_row)
   );

   // Age table: generation difference modulo the generation range.
   logic [AGW-1:0] age_lut [128];
   for (genvar gi = 0; gi < 128; gi++) begin : g_age
      localparam int D = gi - 64;
      localparam int M = ((D % GENERATION_RANGE) + GENERATION_RANGE) % GENERATION_RANGE;
      assign age_lut[gi] = AGW'(M);
   end

   // Per-way terms of the replacement decision.
   logic signed [11:0] way_sc [WAYS];
   logic               way_deep [WAYS];
   logic               way_match [WAYS];
   for (genvar gw = 0; gw < WAYS; gw++) begin : g_way
      logic [6:0] aidx;
      assign aidx = 7'({1'b0, gen_ff} - {1'b0, rd_row[gw].gen} + 7'd64);
      assign way_sc[gw] = {{4{rd_row[gw].depth[7]}}, rd_row[gw].depth}
                          - $signed(12'(age_lut[aidx]) << 2);
      assign way_deep[gw] = $signed({{2{depth_ff[7]}}, depth_ff})
                            >= $signed({{2{rd_row[gw].depth[7]}}, rd_row[gw].depth}) - 10'sd3;
      assign way_match[gw] = rd_row[gw].valid && (rd_row[gw].tag == key_ff[15:0]);
   end

   // Store: first way that is empty or holds the tag, else lowest score (first on ties).
   logic           st_wr;
   logic           st_keep;
   logic [WIX-1:0] st_way;
   always_comb begin
      logic               found;
      logic [WIX-1:0]     best;
      logic signed [11:0] best_sc;
      found   = 1'b0;
      best    = '0;
      best_sc = '0;
      st_wr   = 1'b0;
      st_keep = 1'b0;
      st_way  = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (!found) begin
            if (!rd_row[w].valid) begin
               found  = 1'b1;
               st_wr  = 1'b1;
               st_way = WIX'(w);
            end else if (rd_row[w].tag == key_ff[15:0]) begin
               found   = 1'b1;
               st_wr   = (bound_ff == BOUND_EXACT) || way_deep[w];
               st_keep = (move_ff == 16'd0);
               st_way  = WIX'(w);
            end else if (w == 0 || way_sc[w] < best_sc) begin
               best    = WIX'(w);
               best_sc = way_sc[w];
            end
         end
      end
      if (!found) begin
         st_wr  = 1'b1;
         st_way = best;
      end
   end

   // Probe: first valid way with the tag.
   logic           pr_hit;
   logic [WIX-1:0] pr_way;
   always_comb begin
      pr_hit = 1'b0;
      pr_way = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (!pr_hit && way_match[w]) begin
            pr_hit = 1'b1;
            pr_way = WIX'(w);
         end
      end
   end

   // Write-back row for store and probe.
   row_type exe_row;
   always_comb begin
      exe_row = rd_row;
      if (op_ff == OP_PROBE) begin
         exe_row[pr_way].gen = gen_ff;
      end else begin
         exe_row[st_way].valid = 1'b1;
         exe_row[st_way].depth = depth_ff;
         exe_row[st_way].gen   = gen_ff;
         exe_row[st_way].bound = bound_ff;
         exe_row[st_way].tag   = key_ff[15:0];
         exe_row[st_way].eval  = eval_ff;
         exe_row[st_way].score = score_ff;
         exe_row[st_way].move  = st_keep ? rd_row[st_way].move : move_ff;
      end
   end

   // Fill count and clear sweep counters.
   logic [FRW-1:0] frow_ff;
   logic           pend_ff, pend_last_ff;
   logic [9:0]     acc_ff;
   logic [BW-1:0]  crow_ff;
   logic           frow_last, crow_last;
   logic [CW-1:0]  row_cnt;
   logic [10:0]    acc_sum;

   assign frow_last = (frow_ff == FRW'(FROWS - 1));
   assign crow_last = (crow_ff == BW'(BUCKETS - 1));

   // Current-generation entries of the row read in the previous cycle.
   always_comb begin
      row_cnt = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (rd_row[w].valid && rd_row[w].gen == gen_ff
             && (!pend_last_ff || w < LAST_WAYS)) begin
            row_cnt = row_cnt + CW'(1);
         end
      end
   end
   assign acc_sum = {1'b0, acc_ff} + 11'(row_cnt);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         pend_last_ff <= 1'b0;
         frow_ff      <= '0;
         crow_ff      <= '0;
         acc_ff       <= '0;
      end else begin
         pend_ff      <= (state_ff == S_FILL);
         pend_last_ff <= (state_ff == S_FILL) && frow_last;
         if (req_fire) begin
            frow_ff <= '0;
            crow_ff <= '0;
            acc_ff  <= '0;
         end else begin
            if (state_ff == S_FILL) begin
               frow_ff <= frow_ff + FRW'(1);
            end
            if (state_ff == S_CLR) begin
               crow_ff <= crow_ff + BW'(1);
            end
            if (pend_ff) begin
               acc_ff <= acc_sum[10] ? 10'd1023 : acc_sum[9:0];
            end
         end
      end
   end

   // Response register.
   logic rsp_free;
   logic rsp_load;
   assign rsp_free = !rsp_valid || rsp_ready;
   assign rsp_load = rsp_free && (((state_ff == S_EXE) && (op_ff == OP_PROBE))
                                  || ((state_ff == S_FEND) && !pend_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         if (state_ff == S_FEND) begin
            rsp_hit        <= 1'b0;
            rsp_move_out   <= '0;
            rsp_score_out  <= '0;
            rsp_eval_out   <= '0;
            rsp_depth_out  <= '0;
            rsp_bound_out  <= '0;
            rsp_fill_count <= acc_ff;
         end else begin
            rsp_hit        <= pr_hit;
            rsp_move_out   <= pr_hit ? rd_row[pr_way].move  : '0;
            rsp_score_out  <= pr_hit ? rd_row[pr_way].score : '0;
            rsp_eval_out   <= pr_hit ? rd_row[pr_way].eval  : '0;
            rsp_depth_out  <= pr_hit ? rd_row[pr_way].depth : '0;
            rsp_bound_out  <= pr_hit ? rd_row[pr_way].bound : '0;
            rsp_fill_count <= '0;
         end
      end
   end

   // Memory port control.
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = bucket_ff;
      wr_en   = 1'b0;
      wr_addr = bucket_ff;
      wr_row  = exe_row;
      if (state_ff == S_RD) begin
         rd_en = 1'b1;
      end
      if (state_ff == S_FILL) begin
         rd_en   = 1'b1;
         rd_addr = BW'(frow_ff);
      end
      if (state_ff == S_EXE) begin
         wr_en = (op_ff == OP_STORE) ? st_wr : (pr_hit && rsp_free);
      end
      if (state_ff == S_CLR) begin
         wr_en   = 1'b1;
         wr_addr = crow_ff;
         wr_row  = '0;
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               priority if (op_type'(req_operation) == OP_FILL) begin
                  state_in = S_FILL;
               end else if (op_type'(req_operation) == OP_CLEAR) begin
                  state_in = S_CLR;
               end else begin
                  state_in = S_MUL;
               end
            end
         end
         S_MUL:  state_in = S_RD;
         S_RD:   state_in = S_EXE;
         S_EXE: begin
            if (op_ff == OP_STORE || rsp_free) begin
               state_in = S_IDLE;
            end
         end
         S_FILL: begin
            if (frow_last) begin
               state_in = S_FEND;
            end
         end
         S_FEND: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         S_CLR: begin
            if (crow_last) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   // Reset always starts the clearing sweep from the first bucket.
   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> (state_ff == S_CLR) && (crow_ff == '0))
      else $error("reset did not start the clearing sweep");

   // Memory writes come only from the update step or the clearing sweep.
   a_write_source: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_EXE) || (state_ff == S_CLR))
      else $error("unexpected memory write");

   // A new response comes only from a probe or the end of a fill count.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == S_EXE) || ($past(state_ff) == S_FEND))
      else $error("response without a source");

   // The fill sweep never reads past the sampled rows.
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FILL) |-> (32'(frow_ff) < FROWS))
      else $error("fill sweep out of range");
`endif

endmodule

>>> sim/tb_bucketed_hash_table_replacement.sv
// Self-checking testbench for bucketed_hash_table_replacement: directed and random
// store, probe, fill and clear beats checked against an in-bench table predictor.
// Depends on bhtr_pkg and the block's RTL.
module tb_bucketed_hash_table_replacement;
   timeunit 1ns;
   timeprecision 1ps;
   import bhtr_pkg::*;

   localparam int NUM_BUCKETS = BUCKETS_DEFAULT;
   localparam int NUM_WAYS    = WAYS_DEFAULT;
   localparam int NUM_SLOTS   = NUM_BUCKETS * NUM_WAYS;
   localparam int FILL_SLOTS  = (FILL_SAMPLES_DEFAULT < NUM_SLOTS) ?
                                FILL_SAMPLES_DEFAULT : NUM_SLOTS;
   localparam int SETTLE_CYCLES = NUM_BUCKETS + 100;
   localparam int CYCLE_LIMIT   = 3000000;

   typedef struct {
      op_type             op;
      logic [63:0]        key;
      logic [5:0]         gen;
      logic [15:0]        move;
      logic signed [15:0] score;
      logic signed [15:0] eval;
      logic signed [7:0]  depth;
      logic [1:0]         bound;
   } request_type;

   typedef struct {
      logic               hit;
      logic [15:0]        move;
      logic signed [15:0] score;
      logic signed [15:0] eval;
      logic signed [7:0]  depth;
      logic [1:0]         bound;
      logic [9:0]         fill;
   } answer_type;

   logic               clock;
   logic               reset;
   logic               csr_write_enable;
   logic [10:0]        csr_write_data;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_operation;
   logic [63:0]        req_key;
   logic [5:0]         req_generation;
   logic [15:0]        req_move_in;
   logic signed [15:0] req_score_in;
   logic signed [15:0] req_eval_in;
   logic signed [7:0]  req_depth_in;
   logic [1:0]         req_bound_in;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_hit;
   logic [15:0]        rsp_move_out;
   logic signed [15:0] rsp_score_out;
   logic signed [15:0] rsp_eval_out;
   logic signed [7:0]  rsp_depth_out;
   logic [1:0]         rsp_bound_out;
   logic [9:0]         rsp_fill_count;

   bucketed_hash_table_replacement dut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_operation(req_operation), .req_key(req_key),
      .req_generation(req_generation), .req_move_in(req_move_in),
      .req_score_in(req_score_in), .req_eval_in(req_eval_in),
      .req_depth_in(req_depth_in), .req_bound_in(req_bound_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_hit(rsp_hit), .rsp_move_out(rsp_move_out),
      .rsp_score_out(rsp_score_out), .rsp_eval_out(rsp_eval_out),
      .rsp_depth_out(rsp_depth_out), .rsp_bound_out(rsp_bound_out),
      .rsp_fill_count(rsp_fill_count)
   );

   // Shadow of the table and its register.
   slot_type    shadow_slots[NUM_SLOTS];
   logic [10:0] shadow_buckets;

   request_type pending_requests[$];
   request_type current_request;
   answer_type  expected_answers[$];
   int send_idle_pct;
   int stall_pct;
   int mismatches;
   int answers_seen;
   int requests_sent;
   longint cycles;
   logic [63:0] key_pool[24];

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int bucket_of_key(logic [63:0] key);
      logic [10:0] scale;
      logic [74:0] product;
      scale = (shadow_buckets > 11'd1024) ? 11'd1024 : shadow_buckets;
      product = {11'b0, key} * {64'b0, scale};
      return int'(product[74:64]);
   endfunction

   function automatic void clear_shadow();
      foreach (shadow_slots[i]) shadow_slots[i] = '0;
   endfunction

   function automatic void write_slot(int s, request_type r);
      slot_type e;
      logic [15:0] mv;
      e = shadow_slots[s];
      mv = r.move;
      // A null move keeps the move already held under the same tag.
      if (mv == 16'd0 && e.valid && e.tag == r.key[15:0]) mv = e.move;
      e.valid = 1'b1;
      e.depth = r.depth;
      e.gen   = r.gen;
      e.bound = r.bound;
      e.tag   = r.key[15:0];
      e.eval  = r.eval;
      e.score = r.score;
      e.move  = mv;
      shadow_slots[s] = e;
   endfunction

   function automatic void store_entry(request_type r);
      int base, best, best_value, value, sd;
      logic [5:0] age;
      base = bucket_of_key(r.key) * NUM_WAYS;
      best = 0;
      best_value = 0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (!shadow_slots[base + w].valid) begin
            write_slot(base + w, r);
            return;
         end
         sd = int'(shadow_slots[base + w].depth);
         if (shadow_slots[base + w].tag == r.key[15:0]) begin
            if (r.bound == BOUND_EXACT || int'(r.depth) >= sd - 3)
               write_slot(base + w, r);
            return;
         end
         age = r.gen - shadow_slots[base + w].gen;
         value = sd - 4 * int'(age);
         if (w == 0 || value < best_value) begin
            best = w;
            best_value = value;
         end
      end
      write_slot(base + best, r);
   endfunction

   // Applies one accepted beat to the shadow and queues any answer it owes.
   function automatic void predict_table(request_type r);
      answer_type a;
      int base, n;
      a = '{default: '0};
      case (r.op)
         OP_STORE: store_entry(r);
         OP_CLEAR: clear_shadow();
         OP_PROBE: begin
            base = bucket_of_key(r.key) * NUM_WAYS;
            for (int w = 0; w < NUM_WAYS; w++) begin
               if (!a.hit && shadow_slots[base + w].valid &&
                   shadow_slots[base + w].tag == r.key[15:0]) begin
                  shadow_slots[base + w].gen = r.gen;
                  a.hit   = 1'b1;
                  a.move  = shadow_slots[base + w].move;
                  a.score = shadow_slots[base + w].score;
                  a.eval  = shadow_slots[base + w].eval;
                  a.depth = shadow_slots[base + w].depth;
                  a.bound = shadow_slots[base + w].bound;
               end
            end
            expected_answers.push_back(a);
         end
         default: begin
            n = 0;
            for (int i = 0; i < FILL_SLOTS; i++)
               if (shadow_slots[i].valid && shadow_slots[i].gen == r.gen) n++;
            a.fill = (n > 1023) ? 10'd1023 : n[9:0];
            expected_answers.push_back(a);
         end
      endcase
   endfunction

   // Request driver: presents queued beats with random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_table(current_request);
            requests_sent++;
         end
         if (!req_valid || req_ready) begin
            if (pending_requests.size() != 0 &&
                $urandom_range(99) >= send_idle_pct) begin
               current_request = pending_requests.pop_front();
               req_valid      <= 1'b1;
               req_operation  <= current_request.op;
               req_key        <= current_request.key;
               req_generation <= current_request.gen;
               req_move_in    <= current_request.move;
               req_score_in   <= current_request.score;
               req_eval_in    <= current_request.eval;
               req_depth_in   <= current_request.depth;
               req_bound_in   <= current_request.bound;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Answer monitor: random back-pressure and field-by-field comparison.
   always @(posedge clock) begin
      answer_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
         if (rsp_valid && rsp_ready) begin
            answers_seen++;
            if (expected_answers.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("ERROR: answer beat with none expected");
            end else begin
               e = expected_answers.pop_front();
               if (rsp_hit !== e.hit || rsp_move_out !== e.move ||
                   rsp_score_out !== e.score || rsp_eval_out !== e.eval ||
                   rsp_depth_out !== e.depth || rsp_bound_out !== e.bound ||
                   rsp_fill_count !== e.fill) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("ERROR: answer %0d expected hit=%0d move=%h score=%0d eval=%0d",
                              answers_seen, e.hit, e.move, e.score, e.eval);
                     $display("   depth=%0d bound=%0d fill=%0d", e.depth, e.bound, e.fill);
                     $display("   got hit=%0d move=%h score=%0d eval=%0d",
                              rsp_hit, rsp_move_out, rsp_score_out, rsp_eval_out);
                     $display("   depth=%0d bound=%0d fill=%0d",
                              rsp_depth_out, rsp_bound_out, rsp_fill_count);
                  end
               end
            end
         end
      end
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("bucketed_hash_table_replacement verification failed");
         $finish;
      end
   end

   function automatic request_type make_request(op_type op, logic [63:0] key,
                                                logic [5:0] gen, logic [15:0] move,
                                                logic signed [15:0] score,
                                                logic signed [15:0] eval,
                                                logic signed [7:0] depth,
                                                logic [1:0] bound);
      request_type r;
      r.op = op; r.key = key; r.gen = gen; r.move = move;
      r.score = score; r.eval = eval; r.depth = depth; r.bound = bound;
      return r;
   endfunction

   function automatic logic [63:0] random_key();
      return {$urandom, $urandom};
   endfunction

   task automatic wait_idle();
      while (pending_requests.size() != 0 || req_valid || expected_answers.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_bucket_count(logic [10:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      shadow_buckets = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Random traffic over a small key pool so tags collide and buckets fill.
   task automatic queue_random(int count);
      request_type r;
      int pick;
      logic [5:0] base_gen;
      base_gen = $urandom_range(63);
      foreach (key_pool[i]) key_pool[i] = random_key();
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         r.op = (pick < 55) ? OP_STORE : (pick < 90) ? OP_PROBE :
                (pick < 97) ? OP_FILL : OP_CLEAR;
         r.key = ($urandom_range(9) == 0) ? random_key() : key_pool[$urandom_range(23)];
         if ($urandom_range(49) == 0) base_gen = base_gen + 6'd1;
         r.gen = ($urandom_range(4) == 0) ? 6'($urandom_range(63))
                                          : base_gen + 6'($urandom_range(3));
         r.move  = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom);
         r.score = 16'($urandom);
         r.eval  = 16'($urandom);
         r.depth = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(40));
         r.bound = 2'($urandom_range(3));
         pending_requests.push_back(r);
      end
   endtask

   task automatic queue_directed();
      logic [63:0] k0, k1, k2, k3;
      // Four tags in one bucket at the full bucket count; tag zero included.
      k0 = {10'h155, 38'h12345, 16'h0000};
      k1 = {10'h155, 38'h2aaaa, 16'hffff};
      k2 = {10'h155, 38'h05555, 16'h8001};
      k3 = {10'h155, 38'h3ffff, 16'h7ffe};
      pending_requests.push_back(make_request(OP_PROBE, k0, 6'd0, 0, 0, 0, 0, 0));
      pending_requests.push_back(make_request(OP_STORE, k0, 6'd5, 16'hffff,
                                              16'sh7fff, -16'sh8000, 8'sd127, 2'd1));
      pending_requests.push_back(make_request(OP_PROBE, k0, 6'd6, 0, 0, 0, 0, 0));
      // Shallow non-exact store on the same tag is refused.
      pending_requests.push_back(make_request(OP_STORE, k0, 6'd6, 16'h1234,
                                              16'sd1, 16'sd2, 8'sd3, 2'd2));
      pending_requests.push_back(make_request(OP_PROBE, k0, 6'd6, 0, 0, 0, 0, 0));
      // Exact bound always overwrites; a null move keeps the stored move.
      pending_requests.push_back(make_request(OP_STORE, k0, 6'd6, 16'h0000,
                                              -16'sh8000, 16'sh7fff, -8'sd128, 2'd0));
      pending_requests.push_back(make_request(OP_PROBE, k0, 6'd63, 0, 0, 0, 0, 0));
      pending_requests.push_back(make_request(OP_STORE, k1, 6'd63, 16'h0001,
                                              16'sd5, 16'sd6, 8'sd10, 2'd3));
      pending_requests.push_back(make_request(OP_STORE, k2, 6'd0, 16'h8000,
                                              16'sd7, 16'sd8, 8'sd20, 2'd1));
      // Bucket full: the lowest depth-minus-age way is replaced.
      pending_requests.push_back(make_request(OP_STORE, k3, 6'd2, 16'h4242,
                                              16'sd9, 16'sd10, 8'sd0, 2'd2));
      pending_requests.push_back(make_request(OP_PROBE, k0, 6'd2, 0, 0, 0, 0, 0));
      pending_requests.push_back(make_request(OP_PROBE, k1, 6'd2, 0, 0, 0, 0, 0));
      pending_requests.push_back(make_request(OP_PROBE, k2, 6'd2, 0, 0, 0, 0, 0));
      pending_requests.push_back(make_request(OP_PROBE, k3, 6'd2, 0, 0, 0, 0, 0));
      pending_requests.push_back(make_request(OP_FILL, 64'hffff_ffff_ffff_ffff, 6'd2,
                                              16'hffff, -16'sd1, -16'sd1, -8'sd1, 2'd3));
      pending_requests.push_back(make_request(OP_FILL, 64'd0, 6'd63, 0, 0, 0, 0, 0));
      pending_requests.push_back(make_request(OP_STORE, 64'hffff_ffff_ffff_ffff, 6'd63,
                                              16'hffff, -16'sd1, -16'sd1, -8'sd1, 2'd3));
      pending_requests.push_back(make_request(OP_STORE, 64'd0, 6'd0, 16'd0,
                                              16'sd0, 16'sd0, 8'sd0, 2'd0));
      pending_requests.push_back(make_request(OP_PROBE, 64'hffff_ffff_ffff_ffff, 6'd0,
                                              0, 0, 0, 0, 0));
      pending_requests.push_back(make_request(OP_CLEAR, k0, 6'd0, 0, 0, 0, 0, 0));
      pending_requests.push_back(make_request(OP_PROBE, k0, 6'd0, 0, 0, 0, 0, 0));
      pending_requests.push_back(make_request(OP_FILL, k0, 6'd63, 0, 0, 0, 0, 0));
   endtask

   // Phase sequencer: register setting, idle mix, then traffic.
   initial begin
      logic [10:0] settings[7];
      int send_mix[7];
      int stall_mix[7];
      settings  = '{11'd1024, 11'd1, 11'd0, 11'd2047, 11'd7, 11'd300, 11'd1024};
      send_mix  = '{0, 0, 47, 0, 18, 0, 47};
      stall_mix = '{0, 0, 0, 47, 18, 0, 47};
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_valid = 1'b0;
      req_operation = OP_STORE;
      req_key = '0;
      req_generation = '0;
      req_move_in = '0;
      req_score_in = '0;
      req_eval_in = '0;
      req_depth_in = '0;
      req_bound_in = '0;
      rsp_ready = 1'b0;
      mismatches = 0;
      answers_seen = 0;
      requests_sent = 0;
      cycles = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      shadow_buckets = BUCKET_COUNT_RESET;
      clear_shadow();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (!req_ready) @(posedge clock);
      for (int p = 0; p < 7; p++) begin
         write_bucket_count(settings[p]);
         send_idle_pct = send_mix[p];
         stall_pct = stall_mix[p];
         if (p == 0) queue_directed();
         queue_random(200);
         wait_idle();
      end
      $display("Covered %0d request beats and %0d answer beats over seven bucket counts",
               requests_sent, answers_seen);
      $display("with idle and stall mixes from none to 47 percent; %0d mismatches.",
               mismatches);
      if (mismatches == 0 && expected_answers.size() == 0) begin
         $display("bucketed_hash_table_replacement verification clean");
      end else begin
         $display("bucketed_hash_table_replacement verification failed");
      end
      $finish;
   end

endmodule
